>>> rtl/core/pcmt_pkg.sv
// Shared constants and control types of the multi-threshold quantizer.
package pcmt_pkg;

    localparam int DEF_MAX_THRESHOLDS = 16;
    localparam int DEF_MAX_CHANNELS   = 64;
    localparam int DEF_VALUE_BITS     = 16;

    localparam int CHANNEL_BITS   = 12;
    localparam int SLOT_BITS      = 4;
    localparam int LEVEL_BITS     = 5;
    localparam int THR_CFG_BITS   = 5;
    localparam int CH_CFG_BITS    = 7;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 7;
    localparam int DIV_BITS       = CH_CFG_BITS;
    localparam int MOD_CNT_BITS   = $clog2(CHANNEL_BITS + 1);

    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLDS_IN_USE = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNELS_IN_USE   = 4'd1;

    localparam logic [THR_CFG_BITS-1:0] THR_CFG_RESET = 5'd16;
    localparam logic [CH_CFG_BITS-1:0]  CH_CFG_RESET  = 7'd64;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic capture;
        logic mod_step;
        logic ram_we;
        logic scan_run;
        logic out_load;
    } pcmt_cmd_t;

    typedef struct packed {
        logic mod_last;
        logic is_load;
        logic scan_done;
    } pcmt_sts_t;

endpackage

>>> rtl/core/pcmt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pcmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/pcmt_ctrl.sv
// Controller state machine that sequences item capture, remainder, table write, scan and result delivery.
module pcmt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pcmt_pkg::pcmt_sts_t sts,
    output pcmt_pkg::pcmt_cmd_t cmd
);
    import pcmt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MOD   = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MOD;
                end
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_last)
                begin
                    state_next = sts.is_load ? ST_WRITE : ST_SCAN;
                end
            end
            ST_WRITE:
            begin
                cmd.ram_we = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("Result loaded over an item that was not taken.");

    a_accept_starts_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MOD))
        else $error("Accepted item did not start the remainder steps.");

    a_scan_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && sts.scan_done) |=> (state_reg == ST_FIN))
        else $error("Finished scan did not move to result delivery.");
`endif

endmodule

>>> rtl/core/pcmt_dp.sv
// Datapath: configuration, channel remainder, threshold table and comparison counter.
module pcmt_dp #(
    parameter int MAX_THRESHOLDS = pcmt_pkg::DEF_MAX_THRESHOLDS,
    parameter int MAX_CHANNELS   = pcmt_pkg::DEF_MAX_CHANNELS,
    parameter int VALUE_BITS     = pcmt_pkg::DEF_VALUE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                op,
    input  logic [pcmt_pkg::CHANNEL_BITS-1:0]   channel,
    input  logic [pcmt_pkg::SLOT_BITS-1:0]      slot,
    input  logic signed [VALUE_BITS-1:0]        value,
    input  logic                                cfg_we,
    input  logic [pcmt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pcmt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  pcmt_pkg::pcmt_cmd_t                 cmd,
    output pcmt_pkg::pcmt_sts_t                 sts,
    output logic [pcmt_pkg::LEVEL_BITS-1:0]     level
);
    import pcmt_pkg::*;

    localparam int DEPTH = MAX_THRESHOLDS * MAX_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(MAX_THRESHOLDS + 1);

    logic                     op_reg;
    logic [CHANNEL_BITS-1:0]  dividend_reg, dividend_next;
    logic [SLOT_BITS-1:0]     slot_reg;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic [DIV_BITS-1:0]      rem_reg, rem_next;
    logic [MOD_CNT_BITS-1:0]  mod_cnt_reg, mod_cnt_next;
    logic [THR_CFG_BITS-1:0]  thr_cfg_reg, thr_cfg_next;
    logic [CH_CFG_BITS-1:0]   ch_cfg_reg, ch_cfg_next;
    logic [NW-1:0]            rd_idx_reg, rd_idx_next;
    logic [AW-1:0]            off_reg, off_next;
    logic                     pend_reg, pend_next;
    logic [NW-1:0]            count_reg, count_next;
    logic [LEVEL_BITS-1:0]    level_reg, level_next;

    logic [DIV_BITS-1:0]      divisor;
    logic [NW-1:0]            n_active;
    logic [DIV_BITS:0]        trial;
    logic                     trial_ge;
    logic                     issue;
    logic                     slot_ok;
    logic                     hit;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic [VALUE_BITS-1:0]    rdata;

    always_comb
    begin
        if (ch_cfg_reg == '0)
        begin
            divisor = DIV_BITS'(1);
        end
        else if (32'(ch_cfg_reg) > MAX_CHANNELS)
        begin
            divisor = DIV_BITS'(MAX_CHANNELS);
        end
        else
        begin
            divisor = ch_cfg_reg;
        end

        if (32'(thr_cfg_reg) > MAX_THRESHOLDS)
        begin
            n_active = NW'(MAX_THRESHOLDS);
        end
        else
        begin
            n_active = NW'(thr_cfg_reg);
        end
    end

    assign trial    = {rem_reg, dividend_reg[CHANNEL_BITS-1]};
    assign trial_ge = trial >= {1'b0, divisor};
    assign issue    = rd_idx_reg < n_active;
    assign slot_ok  = 32'(slot_reg) < MAX_THRESHOLDS;
    assign rd_addr  = AW'(32'(off_reg) + 32'(rem_reg));
    assign wr_addr  = AW'(32'(slot_reg) * MAX_CHANNELS + 32'(rem_reg));
    assign hit      = value_reg >= $signed(rdata);

    always_comb
    begin
        thr_cfg_next  = thr_cfg_reg;
        ch_cfg_next   = ch_cfg_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        mod_cnt_next  = mod_cnt_reg;
        rd_idx_next   = rd_idx_reg;
        off_next      = off_reg;
        pend_next     = pend_reg;
        count_next    = count_reg;
        level_next    = level_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLDS_IN_USE: thr_cfg_next = cfg_data[THR_CFG_BITS-1:0];
                REG_CHANNELS_IN_USE:   ch_cfg_next  = cfg_data[CH_CFG_BITS-1:0];
                default: ;
            endcase
        end

        if (cmd.capture)
        begin
            dividend_next = channel;
            rem_next      = '0;
            mod_cnt_next  = MOD_CNT_BITS'(CHANNEL_BITS);
            rd_idx_next   = '0;
            off_next      = '0;
            pend_next     = 1'b0;
            count_next    = '0;
        end

        if (cmd.mod_step)
        begin
            dividend_next = {dividend_reg[CHANNEL_BITS-2:0], 1'b0};
            rem_next      = trial_ge ? DIV_BITS'(trial - {1'b0, divisor})
                                     : trial[DIV_BITS-1:0];
            mod_cnt_next  = mod_cnt_reg - 1'b1;
        end

        if (cmd.scan_run)
        begin
            pend_next = issue;
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
                off_next    = AW'(32'(off_reg) + MAX_CHANNELS);
            end
            if (pend_reg && hit)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        if (cmd.out_load)
        begin
            level_next = LEVEL_BITS'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_cfg_reg <= THR_CFG_RESET;
            ch_cfg_reg  <= CH_CFG_RESET;
            mod_cnt_reg <= '0;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            thr_cfg_reg <= thr_cfg_next;
            ch_cfg_reg  <= ch_cfg_next;
            mod_cnt_reg <= mod_cnt_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            slot_reg  <= slot;
            value_reg <= value;
        end
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        off_reg      <= off_next;
        count_reg    <= count_next;
        level_reg    <= level_next;
    end

    pcmt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.ram_we && slot_ok),
        .waddr (wr_addr),
        .wdata (value_reg),
        .re    (cmd.scan_run && issue),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign sts.mod_last  = (mod_cnt_reg == MOD_CNT_BITS'(1));
    assign sts.is_load   = (op_reg == OP_LOAD);
    assign sts.scan_done = !issue && !pend_reg;
    assign level         = level_reg;

endmodule

>>> rtl/core/per_channel_multi_threshold.sv
// Top level of the per-channel multi-threshold activation quantizer.
// A load item (op 0) stores a signed threshold at its slot and channel; a sample item (op 1)
// returns the number of the first thresholds_in_use thresholds of its channel that the sample
// meets or exceeds. The channel of every item is reduced modulo channels_in_use by a
// restoring remainder unit that takes one channel bit per cycle. A load item then writes its
// threshold to the table, and the block is ready again. A sample item reads the table one
// threshold per cycle through the RAM's single registered read port. A finished result sits
// in an output register, and the next item is accepted while it waits. Threshold entries
// must be written before they are used; the table has no reset. Configuration is to be
// written by the user only while the block is idle; the block itself does not enforce it.
module per_channel_multi_threshold #(
    parameter int MAX_THRESHOLDS = pcmt_pkg::DEF_MAX_THRESHOLDS,
    parameter int MAX_CHANNELS   = pcmt_pkg::DEF_MAX_CHANNELS,
    parameter int VALUE_BITS     = pcmt_pkg::DEF_VALUE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [pcmt_pkg::CHANNEL_BITS-1:0]   channel,
    input  logic [pcmt_pkg::SLOT_BITS-1:0]      slot,
    input  logic signed [VALUE_BITS-1:0]        value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pcmt_pkg::LEVEL_BITS-1:0]     level,
    input  logic                                cfg_we,
    input  logic [pcmt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pcmt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import pcmt_pkg::*;

    pcmt_cmd_t cmd;
    pcmt_sts_t sts;

    pcmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pcmt_dp #(
        .MAX_THRESHOLDS (MAX_THRESHOLDS),
        .MAX_CHANNELS   (MAX_CHANNELS),
        .VALUE_BITS     (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .channel   (channel),
        .slot      (slot),
        .value     (value),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .level     (level)
    );

endmodule

>>> dv/tb.sv
// Testbench for the per-channel multi-threshold quantizer with a scoreboard of expected levels.
module tb;
    import pcmt_pkg::*;

    localparam int VB            = DEF_VALUE_BITS;
    localparam int MC            = DEF_MAX_CHANNELS;
    localparam int TABLE_DEPTH   = DEF_MAX_THRESHOLDS * DEF_MAX_CHANNELS;
    localparam int CHANNEL_MAX   = (1 << CHANNEL_BITS) - 1;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int PHASE_ITEMS   = 55;

    typedef struct packed {
        logic                    op;
        logic [CHANNEL_BITS-1:0] channel;
        logic [SLOT_BITS-1:0]    slot;
        logic signed [VB-1:0]    value;
    } quant_item_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      op = OP_LOAD;
    logic [CHANNEL_BITS-1:0]   channel = '0;
    logic [SLOT_BITS-1:0]      slot = '0;
    logic signed [VB-1:0]      value = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [LEVEL_BITS-1:0]     level;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_THRESHOLDS_IN_USE;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    per_channel_multi_threshold uut (
        .clk,
        .rst_n,
        .in_valid,
        .in_ready,
        .op,
        .channel,
        .slot,
        .value,
        .out_valid,
        .out_ready,
        .level,
        .cfg_we,
        .cfg_index,
        .cfg_data
    );

    always #6 clk = ~clk;

    // Predictor state, updated as items are accepted.
    logic signed [VB-1:0]    level_thr [TABLE_DEPTH];
    logic [THR_CFG_BITS-1:0] thr_cfg = THR_CFG_RESET;
    logic [CH_CFG_BITS-1:0]  ch_cfg = CH_CFG_RESET;
    logic [LEVEL_BITS-1:0]   expected_levels [$];

    // Stimulus planning state, updated as items are queued.
    logic signed [VB-1:0] plan_thr [TABLE_DEPTH];
    bit                   plan_written [TABLE_DEPTH];
    quant_item_t          pending_items [$];
    int                   plan_count = 0;

    int   mismatch_count = 0;
    int   accepted_items = 0;
    logic in_fire = 1'b0;
    logic long_hold = 1'b0;

    function automatic int active_thresholds();
        return (thr_cfg > DEF_MAX_THRESHOLDS) ? DEF_MAX_THRESHOLDS : int'(thr_cfg);
    endfunction

    function automatic int active_channels();
        if (ch_cfg == 0)
            return 1;
        return (ch_cfg > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : int'(ch_cfg);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void apply_item(input quant_item_t it);
        int                    r;
        int                    n;
        logic signed [VB-1:0]  v;
        logic [LEVEL_BITS-1:0] cnt;
        r = int'(it.channel) % active_channels();
        v = it.value;
        if (it.op == OP_LOAD)
        begin
            level_thr[int'(it.slot) * MC + r] = v;
        end
        else
        begin
            cnt = '0;
            n = active_thresholds();
            for (int t = 0; t < n; t++)
            begin
                if (v >= level_thr[t * MC + r])
                    cnt++;
            end
            expected_levels.push_back(cnt);
        end
    endfunction

    function automatic logic [CHANNEL_BITS-1:0] raw_channel(input int r);
        int span;
        span = (CHANNEL_MAX - r) / active_channels();
        return CHANNEL_BITS'(r + active_channels() * int'($urandom_range(0, span)));
    endfunction

    function automatic logic signed [VB-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(VB-1){1'b0}}};
            1: return {1'b0, {(VB-1){1'b1}}};
            default: return VB'($urandom);
        endcase
    endfunction

    function automatic void queue_item(input logic o, input logic [CHANNEL_BITS-1:0] ch,
                                       input logic [SLOT_BITS-1:0] s,
                                       input logic signed [VB-1:0] v);
        quant_item_t it;
        int          r;
        it.op = o;
        it.channel = ch;
        it.slot = s;
        it.value = v;
        if (o == OP_LOAD)
        begin
            r = int'(ch) % active_channels();
            plan_thr[int'(s) * MC + r] = v;
            plan_written[int'(s) * MC + r] = 1'b1;
        end
        pending_items.push_back(it);
        plan_count++;
    endfunction

    // Loads any entry the sample would read that was never written, then the sample.
    function automatic void queue_sample(input logic [CHANNEL_BITS-1:0] ch);
        int                   r;
        int                   n;
        int                   t;
        logic signed [VB-1:0] v;
        r = int'(ch) % active_channels();
        n = active_thresholds();
        for (int s = 0; s < n; s++)
        begin
            if (!plan_written[s * MC + r])
                queue_item(OP_LOAD, raw_channel(r), SLOT_BITS'(s), random_value());
        end
        if (n > 0 && $urandom_range(0, 5) < 3)
        begin
            t = $urandom_range(0, n - 1);
            v = plan_thr[t * MC + r] + VB'($urandom_range(0, 2)) - VB'(1);
        end
        else
        begin
            v = random_value();
        end
        queue_item(OP_SAMPLE, ch, SLOT_BITS'($urandom), v);
    endfunction

    function automatic void queue_random(input int n);
        int few;
        plan_count = 0;
        few = (active_channels() < 4) ? active_channels() : 4;
        while (plan_count < n)
        begin
            if ($urandom_range(0, 9) < 3)
                queue_item(OP_LOAD, CHANNEL_BITS'($urandom), SLOT_BITS'($urandom),
                           random_value());
            else if ($urandom_range(0, 1) == 0)
                queue_sample(CHANNEL_BITS'($urandom));
            else
                queue_sample(raw_channel($urandom_range(0, few - 1)));
        end
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_THRESHOLDS_IN_USE)
            thr_cfg = data[THR_CFG_BITS-1:0];
        else if (idx == REG_CHANNELS_IN_USE)
            ch_cfg = data;
    endtask

    task automatic set_config(input int thr, input int ch);
        wait_idle();
        write_reg(REG_THRESHOLDS_IN_USE, CFG_DATA_BITS'(thr));
        write_reg(REG_CHANNELS_IN_USE, CFG_DATA_BITS'(ch));
        @(posedge clk);
    endtask

    // Sender: bursts of items separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin : driver
        quant_item_t it;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                it = pending_items.pop_front();
                op <= it.op;
                channel <= it.channel;
                slot <= it.slot;
                value <= it.value;
                in_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: switches between always ready, random stalls and a fixed pattern.
    int stall_mode = 0;
    int mode_left = 0;
    int stall_phase = 0;

    always @(negedge clk)
    begin : receiver
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(1, 100);
                stall_mode = $urandom_range(0, 2);
            end
            mode_left--;
            stall_phase++;
            if (long_hold)
                out_ready <= 1'b0;
            else if (stall_mode == 0)
                out_ready <= 1'b1;
            else if (stall_mode == 1)
                out_ready <= 1'($urandom_range(0, 1));
            else
                out_ready <= (stall_phase % 4 == 0);
        end
    end

    always @(posedge clk)
    begin : monitor
        logic [LEVEL_BITS-1:0] want;
        in_fire <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                apply_item('{op: op, channel: channel, slot: slot, value: value});
                accepted_items++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    report_mismatch($sformatf("level %0d with no sample waiting", level));
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (level !== want)
                        report_mismatch($sformatf("level %0d, expected %0d", level, want));
                end
            end
        end
    end

    // The receiver holds off once for a long stretch so that the block backs up.
    initial
    begin : long_stall
        while (!(accepted_items >= 100 && pending_items.size() > 20))
            @(posedge clk);
        long_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
    end

    initial
    begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("tb failed");
        $finish;
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Ascending thresholds on the top channel, then samples at the extremes and on ties.
        for (int s = 0; s < DEF_MAX_THRESHOLDS; s++)
            queue_item(OP_LOAD, CHANNEL_BITS'(CHANNEL_MAX), SLOT_BITS'(s),
                       VB'(-32768 + 4096 * s));
        queue_item(OP_SAMPLE, CHANNEL_BITS'(63), 4'hF, VB'(-32768));
        queue_item(OP_SAMPLE, CHANNEL_BITS'(63), 4'h0, VB'(32767));
        queue_item(OP_SAMPLE, CHANNEL_BITS'(63), 4'h5, VB'(0));
        queue_item(OP_SAMPLE, CHANNEL_BITS'(63), 4'hA, VB'(-1));
        queue_item(OP_SAMPLE, CHANNEL_BITS'(63), 4'h3, VB'(-28672));
        queue_item(OP_SAMPLE, CHANNEL_BITS'(63), 4'hC, VB'(28671));
        queue_item(OP_SAMPLE, CHANNEL_BITS'(127), 4'h7, VB'(4096));
        queue_random(PHASE_ITEMS);

        set_config(1, 1);
        queue_random(PHASE_ITEMS);
        set_config(0, 0);
        queue_random(PHASE_ITEMS);
        set_config(31, 127);
        queue_random(PHASE_ITEMS);
        set_config(5, 3);
        queue_random(PHASE_ITEMS);

        // Writes to indexes beyond the two registers must leave the settings alone.
        wait_idle();
        write_reg(CFG_INDEX_BITS'(15), CFG_DATA_BITS'(127));
        write_reg(CFG_INDEX_BITS'(2), CFG_DATA_BITS'(0));
        @(posedge clk);
        queue_random(PHASE_ITEMS);

        repeat (3)
        begin
            set_config($urandom_range(1, 16), $urandom_range(1, 64));
            queue_random(PHASE_ITEMS);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/pcmt_pkg.sv
rtl/core/pcmt_ram.sv
rtl/core/pcmt_ctrl.sv
rtl/core/pcmt_dp.sv
rtl/core/per_channel_multi_threshold.sv
dv/tb.sv
